// ===== rtl/breakpoint_range_match_table_unit_macros.svh =====
// assertion macros for the breakpoint table; all sample on clk and idle in reset
`ifndef BREAKPOINT_RANGE_MATCH_TABLE_UNIT_MACROS_SVH
`define BREAKPOINT_RANGE_MATCH_TABLE_UNIT_MACROS_SVH

// same-cycle implication
`define BRMT_ASSERT_IMP(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define BRMT_ASSERT_NXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

// plain invariant
`define BRMT_ASSERT_ALW(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

`endif

// ===== rtl/brmt_pkg.sv =====
`timescale 1ns / 1ps

package brmt_pkg;

    localparam int MAX_ENTRIES = 256;
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    localparam logic [5:0] TYPE_EXEC = 6'h01;
    localparam int TYPE_ROM_BIT = 4;

    typedef enum logic [1:0] {
        REQ_CHECK     = 2'd0,
        REQ_SET       = 2'd1,
        REQ_CLEAR     = 2'd2,
        REQ_CLEAR_ALL = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_t;

    // request token walking down the cell chain
    typedef struct packed {
        logic             valid;
        req_t             req;
        logic [31:0]      addr;
        logic [7:0]       len;
        logic [5:0]       tmask;
        logic [31:0]      rom_addr;
        logic             rom_test;
        logic [CNT_W-1:0] count;
        logic             flag;
    } tok_t;

    // a in [base, base + len), end formed in 33 bits
    function automatic logic in_window(input logic [31:0] a, input logic [31:0] base,
                                       input logic [7:0] len);
        logic [32:0] win_end;
        win_end = {1'b0, base} + {25'b0, len};
        return (a >= base) && ({1'b0, a} < win_end);
    endfunction

endpackage

// ===== rtl/brmt_cell.sv =====
`timescale 1ns / 1ps

module brmt_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [brmt_pkg::IDX_W-1:0] idx,
    input  brmt_pkg::tok_t            tok_in,
    output brmt_pkg::tok_t            tok_out,
    input  logic [31:0]               nb_addr,
    input  logic [5:0]                nb_type,
    output logic [31:0]               e_addr,
    output logic [5:0]                e_type
);
    import brmt_pkg::*;

    logic [31:0]      e_addr_reg;
    logic [5:0]       e_type_reg;
    logic             tok_valid_reg;
    tok_t             tok_data_reg;
    tok_t             tok_next;
    logic [CNT_W-1:0] idx_ext;
    logic             occupied;
    logic             pair_eq;
    logic             hit_here;
    logic             flag_next;
    logic             write_new;
    logic             shift;

    always_comb
    begin
        idx_ext  = CNT_W'(idx);
        occupied = idx_ext < tok_in.count;
        pair_eq  = occupied && (e_addr_reg == tok_in.addr) && (e_type_reg == tok_in.tmask);
        hit_here = occupied &&
                   (((|(e_type_reg & tok_in.tmask)) &&
                     in_window(e_addr_reg, tok_in.addr, tok_in.len)) ||
                    (tok_in.rom_test && e_type_reg[TYPE_ROM_BIT] &&
                     in_window(e_addr_reg, tok_in.rom_addr, tok_in.len)));
        flag_next = tok_in.flag;
        case (tok_in.req)
            REQ_CHECK:            flag_next = tok_in.flag | hit_here;
            REQ_SET, REQ_CLEAR:   flag_next = tok_in.flag | pair_eq;
            default:              flag_next = tok_in.flag;
        endcase
        tok_next      = tok_in;
        tok_next.flag = flag_next;
        // append lands in the first free slot when no earlier duplicate was seen
        write_new = tok_in.valid && (tok_in.req == REQ_SET) && !tok_in.flag &&
                    (idx_ext == tok_in.count);
        // from the matching slot on, every slot pulls from its upper neighbor
        shift = tok_in.valid && (tok_in.req == REQ_CLEAR) && flag_next;
    end

    always_ff @(posedge clk)
    begin
        if (write_new)
        begin
            e_addr_reg <= tok_in.addr;
            e_type_reg <= tok_in.tmask;
        end
        else if (shift)
        begin
            e_addr_reg <= nb_addr;
            e_type_reg <= nb_type;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            tok_valid_reg <= tok_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_data_reg <= tok_next;
    end

    always_comb
    begin
        tok_out       = tok_data_reg;
        tok_out.valid = tok_valid_reg;
    end

    assign e_addr = e_addr_reg;
    assign e_type = e_type_reg;

endmodule

// ===== rtl/breakpoint_range_match_table_unit.sv =====
`timescale 1ns / 1ps

// Breakpoint table of MAX_ENTRIES (address, type) pairs held in a chain of cells, one pair
// per cell. A request is taken when start is high and busy is low; the request then walks
// the chain one cell per clock, and done pulses for one cycle once the request has left the
// last cell. busy is low again in that done cycle, so a new request can be accepted from it on.
// Every request type walks the whole chain. hit, status and entry_count are set with done
// and hold until the next done; they must be captured then, since there is no way to hold
// them off.

module breakpoint_range_match_table_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 req_type,
    input  logic [31:0]                address,
    input  logic [7:0]                 range_len,
    input  logic [5:0]                 type_mask,
    input  logic [31:0]                rom_address,
    input  logic                       rom_valid,
    output logic                       done,
    output logic                       hit,
    output logic [1:0]                 status,
    output logic [brmt_pkg::CNT_W-1:0] entry_count
);
    import brmt_pkg::*;
    `include "breakpoint_range_match_table_unit_macros.svh"

    tok_t             tok_chain [0:MAX_ENTRIES];
    logic [31:0]      cell_addr [0:MAX_ENTRIES-1];
    logic [5:0]       cell_type [0:MAX_ENTRIES-1];
    logic [MAX_ENTRIES:0] tok_valid_vec;

    logic             head_valid_reg;
    tok_t             head_data_reg;
    logic             busy_reg;
    logic             done_reg;
    logic             hit_reg;
    status_t          status_reg;
    logic [CNT_W-1:0] count_reg;
    logic             accept;
    tok_t             tail;

    assign accept = start && !busy_reg;
    assign tail   = tok_chain[MAX_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            head_data_reg.valid    <= 1'b1;
            head_data_reg.req      <= req_t'(req_type);
            head_data_reg.addr     <= address;
            head_data_reg.len      <= range_len;
            head_data_reg.tmask    <= type_mask;
            head_data_reg.rom_addr <= rom_address;
            head_data_reg.rom_test <= (type_mask == TYPE_EXEC) && rom_valid;
            head_data_reg.count    <= count_reg;
            head_data_reg.flag     <= 1'b0;
        end
    end

    always_comb
    begin
        tok_chain[0]       = head_data_reg;
        tok_chain[0].valid = head_valid_reg;
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ENTRIES; gi++)
        begin : g_cell
            logic [31:0] nb_addr;
            logic [5:0]  nb_type;
            if (gi == MAX_ENTRIES - 1)
            begin : g_last
                assign nb_addr = '0;
                assign nb_type = '0;
            end
            else
            begin : g_mid
                assign nb_addr = cell_addr[gi+1];
                assign nb_type = cell_type[gi+1];
            end
            brmt_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .idx     (IDX_W'(gi)),
                .tok_in  (tok_chain[gi]),
                .tok_out (tok_chain[gi+1]),
                .nb_addr (nb_addr),
                .nb_type (nb_type),
                .e_addr  (cell_addr[gi]),
                .e_type  (cell_type[gi])
            );
        end
        for (gi = 0; gi <= MAX_ENTRIES; gi++)
        begin : g_vld
            assign tok_valid_vec[gi] = tok_chain[gi].valid;
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            busy_reg       <= 1'b0;
            done_reg       <= 1'b0;
            hit_reg        <= 1'b0;
            status_reg     <= ST_OK;
            count_reg      <= '0;
        end
        else
        begin
            head_valid_reg <= accept;
            done_reg       <= tail.valid;
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (tail.valid)
            begin
                busy_reg <= 1'b0;
            end
            if (tail.valid)
            begin
                case (tail.req)
                    REQ_CHECK:
                    begin
                        hit_reg    <= tail.flag;
                        status_reg <= ST_OK;
                    end
                    REQ_SET:
                    begin
                        hit_reg <= 1'b0;
                        // duplicate pair leaves the table alone, even when full
                        if (!tail.flag)
                        begin
                            if (count_reg == CNT_W'(MAX_ENTRIES))
                            begin
                                status_reg <= ST_FULL;
                            end
                            else
                            begin
                                status_reg <= ST_OK;
                                count_reg  <= count_reg + CNT_W'(1);
                            end
                        end
                        else
                        begin
                            status_reg <= ST_OK;
                        end
                    end
                    REQ_CLEAR:
                    begin
                        hit_reg <= 1'b0;
                        if (tail.flag)
                        begin
                            status_reg <= ST_OK;
                            count_reg  <= count_reg - CNT_W'(1);
                        end
                        else
                        begin
                            status_reg <= ST_NOT_FOUND;
                        end
                    end
                    default:
                    begin
                        hit_reg    <= 1'b0;
                        status_reg <= ST_OK;
                        count_reg  <= '0;
                    end
                endcase
            end
        end
    end

    assign busy        = busy_reg;
    assign done        = done_reg;
    assign hit         = hit_reg;
    assign status      = status_reg;
    assign entry_count = count_reg;

    `BRMT_ASSERT_ALW(a_single_token, $onehot0(tok_valid_vec), "more than one transaction in chain")
    `BRMT_ASSERT_NXT(a_accept_busy, accept, busy_reg, "busy not raised after accept")
    `BRMT_ASSERT_IMP(a_hit_status, done_reg && hit_reg, status_reg == ST_OK, "hit with error")
    `BRMT_ASSERT_IMP(a_fail_keeps_count, done_reg && (status_reg != ST_OK),
                     count_reg == $past(count_reg), "failed request changed the count")

endmodule
